// ----- rtl/ccg_pkg.sv -----
// ----------------------------------------------------------------------------
// ccg_pkg
// Shared types and constants of the coulomb-counting charge gauge.
// ----------------------------------------------------------------------------
package ccg_pkg;

  localparam int LEVEL_W = 14;
  localparam int EPOCH_W = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 3;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 3;
  localparam int DIV_STEPS = LEVEL_W;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 14'd10000;

  localparam int CAP_CHANGE_TOL = 100;
  localparam int SEED_TOL       = 10;
  localparam int RESET_CAP_MIN  = 100;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_SAMPLE     = 3'd0;
  localparam logic [OP_W-1:0] OP_RESET_FULL = 3'd1;
  localparam logic [OP_W-1:0] OP_RESTORE    = 3'd2;
  localparam logic [OP_W-1:0] OP_SEED       = 3'd3;
  localparam logic [OP_W-1:0] OP_CAP_CHANGE = 3'd4;

  // Status codes of a result item.
  localparam logic [STAT_W-1:0] ST_TRACKED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_PASSTHROUGH = 3'd1;
  localparam logic [STAT_W-1:0] ST_RESET_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_ACCEPTED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_REJECTED    = 3'd4;

  // Configuration register indexes (paddr bit 2).
  localparam logic REG_SMART_MODE = 1'b0;
  localparam logic REG_PACK_CAP   = 1'b1;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic load_out;
  } ccg_cmd_t;

  typedef struct packed {
    logic div_done;
  } ccg_sts_t;

endpackage

// ----- rtl/coulomb_counting_charge_gauge_unit.sv -----
// ----------------------------------------------------------------------------
// coulomb_counting_charge_gauge_unit
// Coulomb-counting battery gauge: integrates net charge and reports percent.
//
//   port group  direction  handshake          contents
//   in_*        input      in_valid/in_stall   operation and sample fields
//   out_*       output     out_valid/out_stall charge percent, mAh, epoch, status
//   APB         input      psel/penable        smart_mode, pack_capacity_mah
//
// An item's result is offered after the capture, update and divide steps, and
// the next item is accepted only once that result is in the result register,
// so items are not overlapped. The 14-step serial divider that forms
// remaining * 10000 / capacity takes most of that time.
// Reset is synchronous and active low and leaves the tracker empty.
// A stalled result holds the unit after its divide until the result is taken.
// ----------------------------------------------------------------------------
module coulomb_counting_charge_gauge_unit import ccg_pkg::*; #(
  parameter int CHARGE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [LEVEL_W-1:0]     in_controller_level,
  input  logic [CHARGE_BITS-1:0] in_discharged_mah,
  input  logic [CHARGE_BITS-1:0] in_regenerated_mah,
  input  logic [CHARGE_BITS-1:0] in_stored_remaining_mah,
  input  logic [CHARGE_BITS-1:0] in_stored_capacity_mah,
  input  logic [EPOCH_W-1:0]     in_stored_epoch,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEVEL_W-1:0]     out_charge_percent,
  output logic [CHARGE_BITS-1:0] out_remaining_mah,
  output logic [EPOCH_W-1:0]     out_current_epoch,
  output logic [STAT_W-1:0]      out_status
);

  logic                   smart_r;
  logic [CHARGE_BITS-1:0] cap_r;
  logic                   cfg_wr;
  ccg_cmd_t               cmd;
  ccg_sts_t               sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smart_r <= 1'b0;
      cap_r   <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SMART_MODE) begin
        smart_r <= pwdata[0];
      end else begin
        cap_r <= pwdata[CHARGE_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PACK_CAP) ? CFG_DW'(cap_r) : CFG_DW'(smart_r);

  ccg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ccg_dpath #(
    .CHARGE_BITS(CHARGE_BITS)
  ) u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .smart_mode              (smart_r),
    .pack_cap                (cap_r),
    .in_operation            (in_operation),
    .in_controller_level     (in_controller_level),
    .in_discharged_mah       (in_discharged_mah),
    .in_regenerated_mah      (in_regenerated_mah),
    .in_stored_remaining_mah (in_stored_remaining_mah),
    .in_stored_capacity_mah  (in_stored_capacity_mah),
    .in_stored_epoch         (in_stored_epoch),
    .out_charge_percent      (out_charge_percent),
    .out_remaining_mah       (out_remaining_mah),
    .out_current_epoch       (out_current_epoch),
    .out_status              (out_status)
  );

endmodule

// ----- rtl/ccg_div.sv -----
// ----------------------------------------------------------------------------
// ccg_div
// Serial gauge divider: floor(num * 10000 / den), saturated at 10000, zero when den is zero.
// ----------------------------------------------------------------------------
module ccg_div import ccg_pkg::*; #(
  parameter int CHARGE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CHARGE_BITS-1:0] num,
  input  logic [CHARGE_BITS-1:0] den,
  output logic                   done,
  output logic [LEVEL_W-1:0]     quot
);

  localparam int PW = CHARGE_BITS + LEVEL_W;
  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [PW-1:0]      part_r, part_nxt;
  logic [PW-1:0]      dsh_r, dsh_nxt;
  logic [LEVEL_W-1:0] q_r, q_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               zero_r, zero_nxt;
  logic               sat_r, sat_nxt;
  logic               fits;

  // The divisor starts shifted up by 13; when num < den the quotient fits
  // in 14 bits, so one restoring step per quotient bit is enough.
  assign fits = (part_r >= dsh_r);

  always_comb begin
    part_nxt = part_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    sat_nxt  = sat_r;
    if (start) begin
      part_nxt = PW'(num) * PW'(FULL_LEVEL);
      dsh_nxt  = PW'(den) << (DIV_STEPS - 1);
      q_nxt    = '0;
      cnt_nxt  = CW'(DIV_STEPS);
      busy_nxt = 1'b1;
      zero_nxt = (den == '0);
      sat_nxt  = (num >= den);
    end else if (busy_r) begin
      if (fits) begin
        part_nxt = part_r - dsh_r;
      end
      q_nxt   = {q_r[LEVEL_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    part_r <= part_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
    sat_r  <= sat_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1));

  always_comb begin
    priority if (zero_r) begin
      quot = '0;
    end else if (sat_r) begin
      quot = FULL_LEVEL;
    end else begin
      quot = q_r;
    end
  end

endmodule

// ----- rtl/ccg_dpath.sv -----
// ----------------------------------------------------------------------------
// ccg_dpath
// Gauge datapath: item capture, tracker state update, divider, result register.
// ----------------------------------------------------------------------------
module ccg_dpath import ccg_pkg::*; #(
  parameter int CHARGE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ccg_cmd_t               cmd,
  output ccg_sts_t               sts,
  input  logic                   smart_mode,
  input  logic [CHARGE_BITS-1:0] pack_cap,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [LEVEL_W-1:0]     in_controller_level,
  input  logic [CHARGE_BITS-1:0] in_discharged_mah,
  input  logic [CHARGE_BITS-1:0] in_regenerated_mah,
  input  logic [CHARGE_BITS-1:0] in_stored_remaining_mah,
  input  logic [CHARGE_BITS-1:0] in_stored_capacity_mah,
  input  logic [EPOCH_W-1:0]     in_stored_epoch,
  output logic [LEVEL_W-1:0]     out_charge_percent,
  output logic [CHARGE_BITS-1:0] out_remaining_mah,
  output logic [EPOCH_W-1:0]     out_current_epoch,
  output logic [STAT_W-1:0]      out_status
);

  localparam int CB = CHARGE_BITS;
  localparam int SW = CB + 3;

  // Captured item.
  logic [OP_W-1:0]       op_r;
  logic [LEVEL_W-1:0]    level_r;
  logic [CB-1:0]         srem_r, scap_r;
  logic [EPOCH_W-1:0]    sepoch_r;
  logic signed [CB:0]    net_r, net_in;

  // Tracker state.
  logic [CB-1:0]         remaining_r, remaining_nxt;
  logic [CB-1:0]         tracked_r, tracked_nxt;
  logic signed [CB:0]    last_net_r, last_net_nxt;
  logic [LEVEL_W-1:0]    last_level_r, last_level_nxt;
  logic [EPOCH_W-1:0]    epoch_r, epoch_nxt;
  logic                  init_r, init_nxt;
  logic                  first_r, first_nxt;
  logic                  cap_pend_r, cap_pend_nxt;

  // Per-item outcome.
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic                  direct_r, direct_nxt;
  logic                  use_pack_r, use_pack_nxt;

  // Result register.
  logic [LEVEL_W-1:0]    res_pct_r;
  logic [CB-1:0]         res_rem_r;
  logic [EPOCH_W-1:0]    res_epoch_r;
  logic [STAT_W-1:0]     res_status_r;

  logic [LEVEL_W-1:0]    level_sat;
  logic                  cap_diff_big, seed_bad, do_full;
  logic [LEVEL_W-1:0]    full_level;
  logic [CB-1:0]         full_cap, reset_cap, rem_clamped;
  logic signed [CB:0]    base;
  logic signed [SW-1:0]  rem_calc, cap_s;
  logic [CB-1:0]         div_den;
  logic [LEVEL_W-1:0]    div_quot;

  assign net_in = $signed({1'b0, in_discharged_mah}) - $signed({1'b0, in_regenerated_mah});

  assign level_sat = (level_r > FULL_LEVEL) ? FULL_LEVEL : level_r;

  assign cap_diff_big = ({1'b0, tracked_r} > ({1'b0, pack_cap} + (CB+1)'(CAP_CHANGE_TOL))) ||
                        ({1'b0, pack_cap} > ({1'b0, tracked_r} + (CB+1)'(CAP_CHANGE_TOL)));

  assign seed_bad = !init_r || (sepoch_r != epoch_r) ||
                    ((tracked_r != '0) &&
                     ({1'b0, srem_r} > ({1'b0, tracked_r} + (CB+1)'(SEED_TOL))));

  assign reset_cap = (tracked_r > CB'(RESET_CAP_MIN)) ? tracked_r : pack_cap;

  // The first sample after a restore or reset takes its own net charge as
  // the baseline, so it removes nothing from the remaining charge.
  assign base     = first_r ? net_r : last_net_r;
  assign rem_calc = SW'($signed({1'b0, remaining_r})) - SW'(net_r) + SW'(base);
  assign cap_s    = SW'($signed({1'b0, pack_cap}));

  always_comb begin
    if (rem_calc < 0) begin
      rem_clamped = '0;
    end else if (rem_calc > cap_s) begin
      rem_clamped = pack_cap;
    end else begin
      rem_clamped = rem_calc[CB-1:0];
    end
  end

  always_comb begin
    remaining_nxt  = remaining_r;
    tracked_nxt    = tracked_r;
    last_net_nxt   = last_net_r;
    last_level_nxt = last_level_r;
    epoch_nxt      = epoch_r;
    init_nxt       = init_r;
    first_nxt      = first_r;
    cap_pend_nxt   = cap_pend_r;
    status_nxt     = status_r;
    direct_nxt     = direct_r;
    use_pack_nxt   = use_pack_r;
    do_full        = 1'b0;
    full_level     = last_level_r;
    full_cap       = reset_cap;
    if (cmd.exec) begin
      direct_nxt   = 1'b0;
      use_pack_nxt = 1'b0;
      status_nxt   = ST_TRACKED;
      if (op_r == OP_SAMPLE) begin
        if (!smart_mode || (pack_cap == '0)) begin
          direct_nxt = 1'b1;
          status_nxt = ST_PASSTHROUGH;
        end else if (cap_pend_r || !init_r || ((tracked_r != '0) && cap_diff_big)) begin
          do_full    = 1'b1;
          full_level = level_r;
          full_cap   = pack_cap;
          direct_nxt = 1'b1;
          status_nxt = ST_RESET_FULL;
        end else begin
          remaining_nxt  = rem_clamped;
          last_level_nxt = level_r;
          last_net_nxt   = net_r;
          first_nxt      = 1'b0;
          use_pack_nxt   = 1'b1;
        end
      end else begin
        unique case (op_r)
          OP_RESET_FULL: begin
            do_full    = 1'b1;
            status_nxt = ST_RESET_FULL;
          end
          OP_RESTORE: begin
            remaining_nxt = srem_r;
            tracked_nxt   = scap_r;
            epoch_nxt     = sepoch_r;
            init_nxt      = 1'b1;
            last_net_nxt  = '0;
            first_nxt     = 1'b1;
            cap_pend_nxt  = 1'b0;
            status_nxt    = ST_ACCEPTED;
          end
          OP_SEED: begin
            if (seed_bad) begin
              status_nxt = ST_REJECTED;
            end else begin
              remaining_nxt = srem_r;
              status_nxt    = ST_ACCEPTED;
            end
          end
          OP_CAP_CHANGE: begin
            cap_pend_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (do_full) begin
        remaining_nxt  = full_cap;
        tracked_nxt    = full_cap;
        last_level_nxt = full_level;
        last_net_nxt   = '0;
        first_nxt      = 1'b1;
        cap_pend_nxt   = 1'b0;
        init_nxt       = 1'b1;
        epoch_nxt      = epoch_r + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r  <= '0;
      tracked_r    <= '0;
      last_net_r   <= '0;
      last_level_r <= '0;
      epoch_r      <= '0;
      init_r       <= 1'b0;
      first_r      <= 1'b1;
      cap_pend_r   <= 1'b0;
    end else begin
      remaining_r  <= remaining_nxt;
      tracked_r    <= tracked_nxt;
      last_net_r   <= last_net_nxt;
      last_level_r <= last_level_nxt;
      epoch_r      <= epoch_nxt;
      init_r       <= init_nxt;
      first_r      <= first_nxt;
      cap_pend_r   <= cap_pend_nxt;
    end
    status_r   <= status_nxt;
    direct_r   <= direct_nxt;
    use_pack_r <= use_pack_nxt;
    if (cmd.capture) begin
      op_r     <= in_operation;
      level_r  <= in_controller_level;
      srem_r   <= in_stored_remaining_mah;
      scap_r   <= in_stored_capacity_mah;
      sepoch_r <= in_stored_epoch;
      net_r    <= net_in;
    end
    if (cmd.load_out) begin
      res_pct_r    <= direct_r ? level_sat : div_quot;
      res_rem_r    <= remaining_r;
      res_epoch_r  <= epoch_r;
      res_status_r <= status_r;
    end
  end

  assign div_den = use_pack_r ? pack_cap : tracked_r;

  ccg_div #(
    .CHARGE_BITS(CHARGE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (remaining_r),
    .den   (div_den),
    .done  (sts.div_done),
    .quot  (div_quot)
  );

  assign out_charge_percent = res_pct_r;
  assign out_remaining_mah  = res_rem_r;
  assign out_current_epoch  = res_epoch_r;
  assign out_status         = res_status_r;

endmodule

// ----- rtl/ccg_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccg_ctrl
// Gauge sequencer: item handshake, update and divide steps, result handoff.
// ----------------------------------------------------------------------------
module ccg_ctrl import ccg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ccg_cmd_t cmd,
  input  ccg_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register may be reloaded once the previous item is taken.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- verif/ccg_checker.sv -----
// ----------------------------------------------------------------------------
// ccg_checker
// Watches the register port and both item channels of the charge gauge. It
// keeps its own copy of the tracker state, works out the result of every
// accepted item and compares each returned result field by field.
// ----------------------------------------------------------------------------
module ccg_checker import ccg_pkg::*; #(
  parameter int CHARGE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  input  logic                   pready,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [LEVEL_W-1:0]     in_controller_level,
  input  logic [CHARGE_BITS-1:0] in_discharged_mah,
  input  logic [CHARGE_BITS-1:0] in_regenerated_mah,
  input  logic [CHARGE_BITS-1:0] in_stored_remaining_mah,
  input  logic [CHARGE_BITS-1:0] in_stored_capacity_mah,
  input  logic [EPOCH_W-1:0]     in_stored_epoch,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [LEVEL_W-1:0]     out_charge_percent,
  input  logic [CHARGE_BITS-1:0] out_remaining_mah,
  input  logic [EPOCH_W-1:0]     out_current_epoch,
  input  logic [STAT_W-1:0]      out_status,
  output int                     fail_count,
  output int                     outstanding,
  output int                     checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = CHARGE_BITS;

  typedef struct packed {
    logic [LEVEL_W-1:0] pct;
    logic [CB-1:0]      rem;
    logic [EPOCH_W-1:0] epoch;
    logic [STAT_W-1:0]  status;
  } gauge_result_t;

  // Register copies.
  logic          smart_q;
  logic [CB-1:0] pack_cap_q;

  // Tracker copy.
  logic [CB-1:0]      rem_mah;
  logic [CB-1:0]      trk_cap;
  logic signed [CB:0] base_net;
  logic [LEVEL_W-1:0] held_level;
  logic [EPOCH_W-1:0] epoch_q;
  logic               have_state;
  logic               first_pending;
  logic               cap_flagged;

  gauge_result_t expected_results[$];

  initial begin
    fail_count    = 0;
    checked_count = 0;
    outstanding   = 0;
  end

  function automatic logic [LEVEL_W-1:0] clip_level(input logic [63:0] v);
    return (v > 64'(FULL_LEVEL)) ? FULL_LEVEL : v[LEVEL_W-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] charge_pct(input logic [CB-1:0] r,
                                                    input logic [CB-1:0] c);
    if (c == '0) return '0;
    return clip_level((64'(r) * 64'd10000) / 64'(c));
  endfunction

  function void go_full(input logic [LEVEL_W-1:0] lvl, input logic [CB-1:0] c);
    rem_mah       = c;
    trk_cap       = c;
    held_level    = lvl;
    base_net      = '0;
    first_pending = 1'b1;
    cap_flagged   = 1'b0;
    have_state    = 1'b1;
    epoch_q       = epoch_q + EPOCH_W'(1);
  endfunction

  function gauge_result_t next_result(input logic [OP_W-1:0] op,
                                      input logic [LEVEL_W-1:0] lvl,
                                      input logic [CB-1:0] dis,
                                      input logic [CB-1:0] regen,
                                      input logic [CB-1:0] srem,
                                      input logic [CB-1:0] scap,
                                      input logic [EPOCH_W-1:0] sep);
    gauge_result_t      r;
    logic signed [CB:0] net;
    logic [CB-1:0]      cap_diff;
    longint             new_rem;
    logic               resetting;
    r = '0;
    r.status = ST_TRACKED;
    if (op == OP_SAMPLE) begin
      if (!smart_q || pack_cap_q == '0) begin
        r.pct    = clip_level(64'(lvl));
        r.status = ST_PASSTHROUGH;
      end else begin
        net = $signed({1'b0, dis}) - $signed({1'b0, regen});
        cap_diff = (trk_cap > pack_cap_q) ? trk_cap - pack_cap_q : pack_cap_q - trk_cap;
        resetting = cap_flagged || !have_state ||
                    (trk_cap != '0 && cap_diff > CB'(CAP_CHANGE_TOL));
        // The first sample after a restore only sets the net charge baseline.
        if (!resetting && first_pending) begin
          base_net      = net;
          first_pending = 1'b0;
        end
        if (resetting) begin
          go_full(lvl, pack_cap_q);
          r.pct    = clip_level(64'(lvl));
          r.status = ST_RESET_FULL;
        end else begin
          new_rem    = longint'(rem_mah) - (longint'(net) - longint'(base_net));
          held_level = lvl;
          base_net   = net;
          if (new_rem < 0) new_rem = 0;
          if (new_rem > longint'(pack_cap_q)) new_rem = longint'(pack_cap_q);
          rem_mah = new_rem[CB-1:0];
          r.pct   = charge_pct(rem_mah, pack_cap_q);
        end
      end
    end else begin
      case (op)
        OP_RESET_FULL: begin
          go_full(held_level, (trk_cap > CB'(RESET_CAP_MIN)) ? trk_cap : pack_cap_q);
          r.status = ST_RESET_FULL;
        end
        OP_RESTORE: begin
          rem_mah       = srem;
          trk_cap       = scap;
          epoch_q       = sep;
          have_state    = 1'b1;
          base_net      = '0;
          first_pending = 1'b1;
          cap_flagged   = 1'b0;
          r.status      = ST_ACCEPTED;
        end
        OP_SEED: begin
          if (!have_state || sep != epoch_q ||
              (trk_cap != '0 && 64'(srem) > 64'(trk_cap) + 64'(SEED_TOL))) begin
            r.status = ST_REJECTED;
          end else begin
            rem_mah  = srem;
            r.status = ST_ACCEPTED;
          end
        end
        OP_CAP_CHANGE: cap_flagged = 1'b1;
        default: ;
      endcase
      r.pct = charge_pct(rem_mah, trk_cap);
    end
    r.rem   = rem_mah;
    r.epoch = epoch_q;
    return r;
  endfunction

  function automatic int field_bad(input string name, input logic [63:0] want,
                                   input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    gauge_result_t want;
    if (!rst_n) begin
      smart_q       = 1'b0;
      pack_cap_q    = '0;
      rem_mah       = '0;
      trk_cap       = '0;
      base_net      = '0;
      held_level    = '0;
      epoch_q       = '0;
      have_state    = 1'b0;
      first_pending = 1'b1;
      cap_flagged   = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PACK_CAP) pack_cap_q = pwdata[CB-1:0];
        else smart_q = pwdata[0];
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending, actual status %0d", $time, out_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          fail_count += field_bad("charge_percent", 64'(want.pct),
                                  64'(out_charge_percent));
          fail_count += field_bad("remaining_mah", 64'(want.rem), 64'(out_remaining_mah));
          fail_count += field_bad("current_epoch", 64'(want.epoch),
                                  64'(out_current_epoch));
          fail_count += field_bad("status", 64'(want.status), 64'(out_status));
          checked_count++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(next_result(in_operation, in_controller_level,
                                               in_discharged_mah, in_regenerated_mah,
                                               in_stored_remaining_mah,
                                               in_stored_capacity_mah, in_stored_epoch));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the coulomb-counting charge gauge. A directed
// sequence walks the corner cases, then random phases with different register
// settings drive mostly realistic telemetry, restores and seeds with random
// gaps and stalls on both channels. The checker module does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import ccg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB             = 24;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 210;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 30;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    in_operation;
  logic [LEVEL_W-1:0] in_controller_level;
  logic [CB-1:0]      in_discharged_mah;
  logic [CB-1:0]      in_regenerated_mah;
  logic [CB-1:0]      in_stored_remaining_mah;
  logic [CB-1:0]      in_stored_capacity_mah;
  logic [EPOCH_W-1:0] in_stored_epoch;
  logic               out_valid;
  logic               out_stall;
  logic [LEVEL_W-1:0] out_charge_percent;
  logic [CB-1:0]      out_remaining_mah;
  logic [EPOCH_W-1:0] out_current_epoch;
  logic [STAT_W-1:0]  out_status;
  int                 fail_count;
  int                 outstanding;
  int                 checked_count;

  // Stimulus bookkeeping.
  logic [CB-1:0]      dis_ctr;
  logic [CB-1:0]      regen_ctr;
  logic [EPOCH_W-1:0] seen_epoch;
  logic               tx_idle_on;
  logic               rx_idle_on;
  int                 rx_long_hold;
  int                 items_sent;
  int                 cfg_writes;
  int                 quiet_cycles;

  logic          phase_smart [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
  logic [CB-1:0] phase_cap   [NUM_PHASES] = '{24'd3000, 24'd2000, 24'hFFFFFF, 24'd1,
                                              24'd0, 24'd2050, 24'd0, 24'd2000};

  coulomb_counting_charge_gauge_unit #(.CHARGE_BITS(CB)) uut (.*);

  ccg_checker #(.CHARGE_BITS(CB)) chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Most recent epoch seen on the result side, used to aim seeds at a match.
  always @(posedge clk) begin
    if (out_valid && !out_stall) seen_epoch <= out_current_epoch;
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: a random hold before each item, or a long one on request.
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = (rx_long_hold > 0) ? rx_long_hold : (rx_idle_on ? $urandom_range(0, 14) : 0);
      rx_long_hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  function automatic logic [LEVEL_W-1:0] rand_level();
    if ($urandom_range(0, 9) == 0) return LEVEL_W'($urandom_range(10001, 16383));
    return LEVEL_W'($urandom_range(0, 10000));
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [LEVEL_W-1:0] lvl,
                           input logic [CB-1:0] dis, input logic [CB-1:0] regen,
                           input logic [CB-1:0] srem, input logic [CB-1:0] scap,
                           input logic [EPOCH_W-1:0] sep);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                <= 1'b1;
    in_operation            <= op;
    in_controller_level     <= lvl;
    in_discharged_mah       <= dis;
    in_regenerated_mah      <= regen;
    in_stored_remaining_mah <= srem;
    in_stored_capacity_mah  <= scap;
    in_stored_epoch         <= sep;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_random(input logic [CB-1:0] hint);
    int            pick;
    int            step_max;
    longint        near_cap;
    logic [CB-1:0] scap;
    pick     = $urandom_range(0, 99);
    step_max = (hint >> 4) + 2;
    if (pick < 74) begin
      dis_ctr += CB'($urandom_range(0, step_max));
      if ($urandom_range(0, 9) < 3) regen_ctr += CB'($urandom_range(0, step_max / 2));
      // Now and then a large charge-back pushes the remaining charge to the top.
      if ($urandom_range(0, 49) == 0) regen_ctr += hint;
      send_item(OP_SAMPLE, rand_level(), dis_ctr, regen_ctr, CB'($urandom), CB'($urandom),
                $urandom);
    end else if (pick < 80) begin
      near_cap = longint'(hint) + $urandom_range(0, 200) - 100;
      if (near_cap < 0) near_cap = 0;
      if (near_cap > 24'hFFFFFF) near_cap = 24'hFFFFFF;
      scap = ($urandom_range(0, 9) == 0) ? CB'($urandom) : near_cap[CB-1:0];
      send_item(OP_RESTORE, rand_level(), CB'($urandom), CB'($urandom),
                CB'($urandom_range(0, scap)), scap,
                ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20));
    end else if (pick < 88) begin
      send_item(OP_SEED, rand_level(), CB'($urandom), CB'($urandom),
                CB'($urandom_range(0, hint + 12)), CB'($urandom),
                ($urandom_range(0, 4) == 0) ? $urandom : seen_epoch);
    end else if (pick < 92) begin
      send_item(OP_RESET_FULL, rand_level(), CB'($urandom), CB'($urandom), CB'($urandom),
                CB'($urandom), $urandom);
    end else if (pick < 95) begin
      send_item(OP_CAP_CHANGE, rand_level(), CB'($urandom), CB'($urandom), CB'($urandom),
                CB'($urandom), $urandom);
    end else if (pick < 97) begin
      send_item(OP_W'($urandom_range(5, 7)), rand_level(), CB'($urandom), CB'($urandom),
                CB'($urandom), CB'($urandom), $urandom);
    end else begin
      send_item(OP_W'($urandom), LEVEL_W'($urandom), CB'($urandom), CB'($urandom),
                CB'($urandom), CB'($urandom), $urandom);
    end
  endtask

  initial begin
    int            mode;
    logic [CB-1:0] hint;
    rst_n                   = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    in_valid                = 1'b0;
    in_operation            = OP_SAMPLE;
    in_controller_level     = '0;
    in_discharged_mah       = '0;
    in_regenerated_mah      = '0;
    in_stored_remaining_mah = '0;
    in_stored_capacity_mah  = '0;
    in_stored_epoch         = '0;
    dis_ctr                 = '0;
    regen_ctr               = '0;
    seen_epoch              = '0;
    tx_idle_on              = 1'b1;
    rx_idle_on              = 1'b1;
    rx_long_hold            = 0;
    items_sent              = 0;
    cfg_writes              = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at reset: samples pass straight through.
    send_item(OP_SAMPLE, 14'd12000, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0);
    send_item(OP_SAMPLE, 14'h3FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              32'hFFFFFFFF);
    send_item(OP_SEED, 14'd0, 24'd0, 24'd0, 24'd5, 24'd0, 32'd0);
    send_item(3'd7, 14'h3FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
    drain();
    write_reg(REG_SMART_MODE, 32'd1);
    write_reg(REG_PACK_CAP, 32'd2000);

    // First use resets to full, then the sample after it sets the baseline.
    send_item(OP_SAMPLE, 14'd9000, 24'd100, 24'd0, 24'd0, 24'd0, 32'd0);
    send_item(OP_SAMPLE, 14'd8800, 24'd100, 24'd0, 24'd0, 24'd0, 32'd0);
    send_item(OP_SAMPLE, 14'd7000, 24'd600, 24'd0, 24'd0, 24'd0, 32'd0);
    send_item(OP_SAMPLE, 14'd7500, 24'd600, 24'd3000, 24'd0, 24'd0, 32'd0);
    send_item(OP_SAMPLE, 14'd0, 24'hFFFFFF, 24'd3000, 24'd0, 24'd0, 32'd0);
    // Seeds: just inside the tolerance, just outside it, and a stale epoch.
    send_item(OP_SEED, 14'd0, 24'd0, 24'd0, 24'd2010, 24'd0, 32'd1);
    send_item(OP_SEED, 14'd0, 24'd0, 24'd0, 24'd2011, 24'd0, 32'd1);
    send_item(OP_SEED, 14'd0, 24'd0, 24'd0, 24'd100, 24'd0, 32'd2);
    send_item(OP_CAP_CHANGE, 14'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0);
    send_item(OP_SAMPLE, 14'd5000, 24'd10, 24'd0, 24'd0, 24'd0, 32'd0);
    // Restore with the largest epoch, so the following reset wraps it.
    send_item(OP_RESTORE, 14'd0, 24'd0, 24'd0, 24'd1000, 24'd2050, 32'hFFFFFFFF);
    send_item(OP_SAMPLE, 14'd4000, 24'd5000, 24'd7, 24'd0, 24'd0, 32'd0);
    send_item(OP_SAMPLE, 14'd3000, 24'd5400, 24'd7, 24'd0, 24'd0, 32'd0);
    send_item(OP_RESET_FULL, 14'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0);
    // A tiny saved capacity makes the reset command fall back to the register.
    send_item(OP_RESTORE, 14'd0, 24'd0, 24'd0, 24'd20, 24'd50, 32'd5);
    send_item(OP_RESET_FULL, 14'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0);
    send_item(OP_RESTORE, 14'd0, 24'd0, 24'd0, 24'd1500, 24'd2200, 32'd7);
    send_item(OP_SAMPLE, 14'd6000, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0);
    // With no tracked capacity any seed fits and the gauge reads zero.
    send_item(OP_RESTORE, 14'd0, 24'd0, 24'd0, 24'd100, 24'd0, 32'd9);
    send_item(OP_SEED, 14'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'd0, 32'd9);
    send_item(OP_CAP_CHANGE, 14'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0);

    phase_cap[6] = CB'($urandom_range(101, 100000));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(REG_SMART_MODE, {31'd0, phase_smart[p]});
      write_reg(REG_PACK_CAP, {8'd0, phase_cap[p]});
      hint = (phase_cap[p] == '0) ? CB'(2000) : phase_cap[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) begin
          mode       = $urandom_range(0, 3);
          tx_idle_on = (mode == 0 || mode == 1);
          rx_idle_on = (mode == 0 || mode == 2);
        end
        // Hold the result side for a long stretch while items keep coming.
        if (p == 2 && i == 100) rx_long_hold = LONG_HOLD;
        send_random(hint);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items across %0d register settings (%0d register writes).",
             items_sent, NUM_PHASES + 1, cfg_writes);
    $display("Compared %0d results against the predicted gauge state.", checked_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
